### rtl/core/scwt_pkg.sv
`default_nettype none

package scwt_pkg;

   localparam int SLOTS        = 12;
   localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int MAX_RESULTS  = 12;
   localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
   localparam int SENSOR_COUNT = 28;
   localparam int BYTE_BITS    = 7;
   localparam int SENSOR_IDX_W = 5;
   localparam int SENSOR_EXT   = 1 << SENSOR_IDX_W;
   localparam int ID_W         = 8;
   localparam int RSP_SLOT_W   = 4;
   localparam int QDEPTH       = 2;
   localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W       = $clog2(QDEPTH + 1);

   localparam logic MODE_SUBSCRIBE = 1'b0;
   localparam logic MODE_FRAME     = 1'b1;

   typedef enum logic [1:0] {
      KIND_STORED   = 2'd0,
      KIND_DROPPED  = 2'd1,
      KIND_RELEASED = 2'd2
   } kind_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_SCAN
   } back_state_type;

   typedef struct packed {
      logic                      mode;
      logic [ID_W-1:0]           waiter_id;
      logic [SENSOR_IDX_W-1:0]   sensor_index;
      logic                      target_level;
      logic [SENSOR_COUNT-1:0]   sensors;
   } cmd_type;

   function automatic logic [SLOT_W-1:0] first_set(input logic [SLOTS-1:0] vec);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = SLOT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

### rtl/core/scwt_front.sv
`default_nettype none

module scwt_front
   import scwt_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_mode,
   input  wire logic [7:0]              req_waiter_id,
   input  wire logic [4:0]              req_sensor_index,
   input  wire logic                    req_target_level,
   input  wire logic [7:0]              req_frame_byte_a,
   input  wire logic [7:0]              req_frame_byte_b,
   input  wire logic [7:0]              req_frame_byte_c,
   input  wire logic [7:0]              req_frame_byte_d,
   output logic                         cmd_valid,
   output cmd_type                      cmd,
   input  wire logic                    cmd_pop
);

   cmd_type             q_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             push_cmd;
   logic                push;
   logic                pop;

   // Only the low seven bits of each byte carry sensors.
   always_comb begin
      push_cmd.mode         = req_mode;
      push_cmd.waiter_id    = req_waiter_id;
      push_cmd.sensor_index = req_sensor_index;
      push_cmd.target_level = req_target_level;
      push_cmd.sensors      = {req_frame_byte_d[BYTE_BITS-1:0], req_frame_byte_c[BYTE_BITS-1:0],
                               req_frame_byte_b[BYTE_BITS-1:0], req_frame_byte_a[BYTE_BITS-1:0]};
   end

   assign req_ready = (count_ff != QCNT_W'(QDEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### rtl/core/scwt_back.sv
`default_nettype none

module scwt_back
   import scwt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_valid,
   input  wire cmd_type     cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_released_id,
   output logic [3:0]       rsp_slot,
   output logic             rsp_last
);

   back_state_type            state_ff, state_in;
   logic [SLOTS-1:0]          slot_valid_ff, slot_valid_in;
   logic [ID_W-1:0]           slot_waiter_ff [SLOTS];
   logic [SENSOR_IDX_W-1:0]   slot_sensor_ff [SLOTS];
   logic                      slot_target_ff [SLOTS];
   logic [SLOTS-1:0]          pend_ff, pend_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      rsp_valid_ff;
   kind_type                  rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]           rsp_id_ff, rsp_id_in;
   logic [RSP_SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      out_space;
   logic                      emit;
   logic                      store_en;
   logic [SLOT_W-1:0]         free_idx;
   logic                      free_any;
   logic [SENSOR_EXT-1:0]     sens_ext;
   logic [SLOTS-1:0]          match;
   logic [SLOT_W-1:0]         pend_idx;
   logic [SLOTS-1:0]          pend_rest;
   logic                      scan_last;
   logic [SLOT_W+RSP_SLOT_W-1:0] free_ext;
   logic [SLOT_W+RSP_SLOT_W-1:0] pend_ext;

   assign out_space = !rsp_valid_ff || rsp_ready;
   assign free_any  = ~&slot_valid_ff;
   assign free_idx  = first_set(~slot_valid_ff);
   assign pend_idx  = first_set(pend_ff);
   assign pend_rest = pend_ff & ~(SLOTS'(1) << pend_idx);
   assign scan_last = (pend_rest == '0) || (cnt_ff == CNT_W'(MAX_RESULTS - 1));
   assign free_ext  = {{RSP_SLOT_W{1'b0}}, free_idx};
   assign pend_ext  = {{RSP_SLOT_W{1'b0}}, pend_idx};
   assign sens_ext  = {{(SENSOR_EXT - SENSOR_COUNT){1'b0}}, cmd.sensors};

   // Sensors beyond the last one read as low.
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match[i] = slot_valid_ff[i] && (sens_ext[slot_sensor_ff[i]] == slot_target_ff[i]);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (cmd_valid && (cmd.mode == MODE_FRAME) && (match != '0)) begin
               state_in = BACK_SCAN;
            end
         end
         BACK_SCAN: begin
            if (out_space && scan_last) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop       = 1'b0;
      emit          = 1'b0;
      store_en      = 1'b0;
      slot_valid_in = slot_valid_ff;
      pend_in       = pend_ff;
      cnt_in        = cnt_ff;
      rsp_kind_in   = KIND_STORED;
      rsp_id_in     = '0;
      rsp_slot_in   = '0;
      rsp_last_in   = 1'b1;
      unique case (state_ff)
         BACK_IDLE: begin
            if (cmd_valid) begin
               if (cmd.mode == MODE_SUBSCRIBE) begin
                  if (out_space) begin
                     cmd_pop = 1'b1;
                     emit    = 1'b1;
                     if (free_any) begin
                        store_en                = 1'b1;
                        slot_valid_in[free_idx] = 1'b1;
                        rsp_kind_in             = KIND_STORED;
                        rsp_id_in               = cmd.waiter_id;
                        rsp_slot_in             = free_ext[RSP_SLOT_W-1:0];
                     end else begin
                        rsp_kind_in = KIND_DROPPED;
                     end
                  end
               end else begin
                  cmd_pop = 1'b1;
                  pend_in = match;
                  cnt_in  = '0;
               end
            end
         end
         BACK_SCAN: begin
            if (out_space) begin
               emit                    = 1'b1;
               slot_valid_in[pend_idx] = 1'b0;
               pend_in                 = pend_rest;
               cnt_in                  = cnt_ff + 1'b1;
               rsp_kind_in             = KIND_RELEASED;
               rsp_id_in               = slot_waiter_ff[pend_idx];
               rsp_slot_in             = pend_ext[RSP_SLOT_W-1:0];
               rsp_last_in             = scan_last;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_IDLE;
         slot_valid_ff <= '0;
         pend_ff       <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         pend_ff       <= pend_in;
         cnt_ff        <= cnt_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         slot_waiter_ff[free_idx] <= cmd.waiter_id;
         slot_sensor_ff[free_idx] <= cmd.sensor_index;
         slot_target_ff[free_idx] <= cmd.target_level;
      end
      if (emit) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_id_ff   <= rsp_id_in;
         rsp_slot_ff <= rsp_slot_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_released_id = rsp_id_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/core/sensor_condition_waiter_table.sv
// Channel    Direction  Handshake            Payload
// req        in         req_valid/req_ready  mode, waiter id, sensor, target, four frame bytes
// rsp        out        rsp_valid/rsp_ready  kind, released id, slot, last
//
// A subscribe item leaves the queue once the output is free and gives its single result.
// A frame item holds the table while its scan gives one result per released waiter.
// Items wait in a two-entry queue, so the input is ready whenever that queue has room.
// A stall on rsp_ready holds the current result and pauses the slot scan.
// Reset is synchronous and clears the queue, every slot's valid bit and the output.
`default_nettype none

module sensor_condition_waiter_table
   import scwt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic [7:0]  req_waiter_id,
   input  wire logic [4:0]  req_sensor_index,
   input  wire logic        req_target_level,
   input  wire logic [7:0]  req_frame_byte_a,
   input  wire logic [7:0]  req_frame_byte_b,
   input  wire logic [7:0]  req_frame_byte_c,
   input  wire logic [7:0]  req_frame_byte_d,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_released_id,
   output logic [3:0]       rsp_slot,
   output logic             rsp_last
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   scwt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_waiter_id    (req_waiter_id),
      .req_sensor_index (req_sensor_index),
      .req_target_level (req_target_level),
      .req_frame_byte_a (req_frame_byte_a),
      .req_frame_byte_b (req_frame_byte_b),
      .req_frame_byte_c (req_frame_byte_c),
      .req_frame_byte_d (req_frame_byte_d),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   scwt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_released_id (rsp_released_id),
      .rsp_slot        (rsp_slot),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

### rtl/core/scwt_checker.sv
`default_nettype none

module scwt_checker
   import scwt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [1:0]  rsp_kind,
   input  wire logic [7:0]  rsp_released_id,
   input  wire logic [3:0]  rsp_slot,
   input  wire logic        rsp_last
);

   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_STORED) || (rsp_kind == KIND_DROPPED)
                    || (rsp_kind == KIND_RELEASED))
      else $error("Result item carries an unknown kind.");

   a_subscribe_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_RELEASED) |-> rsp_last)
      else $error("Subscribe result item is not marked last.");

   a_dropped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DROPPED) |-> (rsp_released_id == '0) && (rsp_slot == '0))
      else $error("Dropped result item carries an id or a slot.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_released_id)
                                  && $stable(rsp_slot) && $stable(rsp_last))
      else $error("Stalled result item changed.");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("Waiting input item was withdrawn.");

endmodule

bind sensor_condition_waiter_table scwt_checker u_scwt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_kind        (rsp_kind),
   .rsp_released_id (rsp_released_id),
   .rsp_slot        (rsp_slot),
   .rsp_last        (rsp_last)
);

`default_nettype wire

### tb/waiter_table_checker.sv
`timescale 1ns / 1ps

module waiter_table_checker
   import scwt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic       req_mode,
   input  wire logic [7:0] req_waiter_id,
   input  wire logic [4:0] req_sensor_index,
   input  wire logic       req_target_level,
   input  wire logic [7:0] req_frame_byte_a,
   input  wire logic [7:0] req_frame_byte_b,
   input  wire logic [7:0] req_frame_byte_c,
   input  wire logic [7:0] req_frame_byte_d,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [1:0] rsp_kind,
   input  wire logic [7:0] rsp_released_id,
   input  wire logic [3:0] rsp_slot,
   input  wire logic       rsp_last,
   output int              mismatches,
   output int              outstanding,
   output int              stored_total,
   output int              dropped_total,
   output int              released_total,
   output int              frame_total
);

   typedef struct packed {
      kind_type                kind;
      logic [ID_W-1:0]         id;
      logic [RSP_SLOT_W-1:0]   slot;
      logic                    last;
   } wake_type;

   wake_type                  due_q[$];
   logic                      slot_busy [SLOTS];
   logic [ID_W-1:0]           slot_id   [SLOTS];
   logic [SENSOR_IDX_W-1:0]   slot_idx  [SLOTS];
   logic                      slot_lvl  [SLOTS];

   int bad_count      = 0;
   int stored_count   = 0;
   int dropped_count  = 0;
   int released_count = 0;
   int frame_count    = 0;
   int due_count      = 0;

   assign mismatches     = bad_count;
   assign outstanding    = due_count;
   assign stored_total   = stored_count;
   assign dropped_total  = dropped_count;
   assign released_total = released_count;
   assign frame_total    = frame_count;

   task automatic report_mismatch(input string what);
      bad_count++;
      if (bad_count <= 30) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
   endtask

   function automatic void apply_item();
      int                      s;
      int                      free_slot;
      int                      hits;
      logic [SENSOR_COUNT-1:0] levels;
      logic                    lvl;
      wake_type                w;
      free_slot = -1;
      hits = 0;
      if (req_mode == MODE_SUBSCRIBE) begin
         for (s = SLOTS - 1; s >= 0; s--) begin
            if (!slot_busy[s]) begin
               free_slot = s;
            end
         end
         w.last = 1'b1;
         if (free_slot >= 0) begin
            slot_busy[free_slot] = 1'b1;
            slot_id[free_slot] = req_waiter_id;
            slot_idx[free_slot] = req_sensor_index;
            slot_lvl[free_slot] = req_target_level;
            w.kind = KIND_STORED;
            w.id = req_waiter_id;
            w.slot = RSP_SLOT_W'(free_slot);
            stored_count++;
         end else begin
            w.kind = KIND_DROPPED;
            w.id = '0;
            w.slot = '0;
            dropped_count++;
         end
         due_q.push_back(w);
      end else begin
         frame_count++;
         levels = {req_frame_byte_d[BYTE_BITS-1:0], req_frame_byte_c[BYTE_BITS-1:0],
                   req_frame_byte_b[BYTE_BITS-1:0], req_frame_byte_a[BYTE_BITS-1:0]};
         for (s = 0; s < SLOTS && hits < MAX_RESULTS; s++) begin
            if (slot_busy[s]) begin
               lvl = (slot_idx[s] < SENSOR_COUNT) ? levels[slot_idx[s]] : 1'b0;
               if (lvl == slot_lvl[s]) begin
                  slot_busy[s] = 1'b0;
                  w.kind = KIND_RELEASED;
                  w.id = slot_id[s];
                  w.slot = RSP_SLOT_W'(s);
                  w.last = 1'b0;
                  due_q.push_back(w);
                  hits++;
                  released_count++;
               end
            end
         end
         if (hits > 0) begin
            due_q[due_q.size() - 1].last = 1'b1;
         end
      end
   endfunction

   task automatic check_result();
      wake_type want;
      if (due_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result kind %0d id %0d slot %0d last %0b",
                                   rsp_kind, rsp_released_id, rsp_slot, rsp_last));
      end else begin
         want = due_q.pop_front();
         if (rsp_kind !== want.kind || rsp_released_id !== want.id ||
             rsp_slot !== want.slot || rsp_last !== want.last) begin
            report_mismatch($sformatf(
               "got kind %0d id %0d slot %0d last %0b, wanted kind %0d id %0d slot %0d last %0b",
               rsp_kind, rsp_released_id, rsp_slot, rsp_last,
               want.kind, want.id, want.slot, want.last));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            slot_busy[s] = 1'b0;
         end
         due_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result();
         end
         if (req_valid && req_ready) begin
            apply_item();
         end
      end
      due_count <= due_q.size();
   end

endmodule

### tb/sensor_condition_waiter_table_tb.sv
`timescale 1ns / 1ps

module sensor_condition_waiter_table_tb;
   import scwt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic       mode;
      logic [7:0] waiter_id;
      logic [4:0] sensor_index;
      logic       target_level;
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic [7:0] byte_c;
      logic [7:0] byte_d;
   } waiter_req_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_mode;
   logic [7:0] req_waiter_id;
   logic [4:0] req_sensor_index;
   logic       req_target_level;
   logic [7:0] req_frame_byte_a;
   logic [7:0] req_frame_byte_b;
   logic [7:0] req_frame_byte_c;
   logic [7:0] req_frame_byte_d;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_released_id;
   logic [3:0] rsp_slot;
   logic       rsp_last;

   int   mismatches;
   int   outstanding;
   int   stored_total;
   int   dropped_total;
   int   released_total;
   int   frame_total;
   int   cycles = 0;
   int   items_sent = 0;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic hold_flip = 1'b0;

   sensor_condition_waiter_table dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_waiter_id    (req_waiter_id),
      .req_sensor_index (req_sensor_index),
      .req_target_level (req_target_level),
      .req_frame_byte_a (req_frame_byte_a),
      .req_frame_byte_b (req_frame_byte_b),
      .req_frame_byte_c (req_frame_byte_c),
      .req_frame_byte_d (req_frame_byte_d),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_released_id  (rsp_released_id),
      .rsp_slot         (rsp_slot),
      .rsp_last         (rsp_last)
   );

   waiter_table_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_waiter_id    (req_waiter_id),
      .req_sensor_index (req_sensor_index),
      .req_target_level (req_target_level),
      .req_frame_byte_a (req_frame_byte_a),
      .req_frame_byte_b (req_frame_byte_b),
      .req_frame_byte_c (req_frame_byte_c),
      .req_frame_byte_d (req_frame_byte_d),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_released_id  (rsp_released_id),
      .rsp_slot         (rsp_slot),
      .rsp_last         (rsp_last),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .stored_total     (stored_total),
      .dropped_total    (dropped_total),
      .released_total   (released_total),
      .frame_total      (frame_total)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // The receiver counts out a long hold-off itself whenever the stimulus flips hold_flip.
   initial begin
      int   hold_left;
      logic hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_flip != hold_seen) begin
            hold_seen = hold_flip;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   function automatic waiter_req_type make_subscribe(input logic [7:0] id,
                                                     input logic [4:0] idx,
                                                     input logic tgt);
      waiter_req_type it;
      it.mode = MODE_SUBSCRIBE;
      it.waiter_id = id;
      it.sensor_index = idx;
      it.target_level = tgt;
      it.byte_a = 8'($urandom);
      it.byte_b = 8'($urandom);
      it.byte_c = 8'($urandom);
      it.byte_d = 8'($urandom);
      return it;
   endfunction

   function automatic waiter_req_type make_frame(input logic [7:0] a, input logic [7:0] b,
                                                 input logic [7:0] c, input logic [7:0] d);
      waiter_req_type it;
      it.mode = MODE_FRAME;
      it.waiter_id = 8'($urandom);
      it.sensor_index = 5'($urandom);
      it.target_level = 1'($urandom);
      it.byte_a = a;
      it.byte_b = b;
      it.byte_c = c;
      it.byte_d = d;
      return it;
   endfunction

   // Indexes beyond the last sensor go with a target of zero here, so that random
   // subscriptions never leave a waiter that can never be released.
   function automatic waiter_req_type random_item(input int sub_pct);
      logic [7:0] fill;
      int         pick;
      if ($urandom_range(99) < sub_pct) begin
         if ($urandom_range(9) == 0) begin
            return make_subscribe(8'($urandom), 5'($urandom_range(31, 28)), 1'b0);
         end
         return make_subscribe(8'($urandom), 5'($urandom_range(27)), 1'($urandom));
      end
      pick = $urandom_range(9);
      case (pick)
         0: fill = 8'h00;
         1: fill = 8'hFF;
         2: fill = 8'h7F;
         3: fill = 8'h80;
         default: begin
            return make_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         end
      endcase
      return make_frame(fill, fill, fill, fill);
   endfunction

   task automatic offer(input waiter_req_type it);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_mode <= it.mode;
      req_waiter_id <= it.waiter_id;
      req_sensor_index <= it.sensor_index;
      req_target_level <= it.target_level;
      req_frame_byte_a <= it.byte_a;
      req_frame_byte_b <= it.byte_b;
      req_frame_byte_c <= it.byte_c;
      req_frame_byte_d <= it.byte_d;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   initial begin
      int         phase;
      int         sub_pct;
      logic [7:0] id;
      logic [4:0] idx;
      logic       tgt;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= MODE_SUBSCRIBE;
      req_waiter_id <= '0;
      req_sensor_index <= '0;
      req_target_level <= 1'b0;
      req_frame_byte_a <= '0;
      req_frame_byte_b <= '0;
      req_frame_byte_c <= '0;
      req_frame_byte_d <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // A frame on an empty table, then twelve waiters to fill it and one that is dropped.
      offer(make_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF));
      for (int i = 0; i < SLOTS; i++) begin
         id = (i == 0) ? 8'h00 : (i == SLOTS - 1) ? 8'hFF : 8'(16 * i + 3);
         idx = (i == 0) ? 5'd0 : (i == SLOTS - 1) ? 5'd27 : 5'(2 * i);
         tgt = 1'b1;
         if (i == 5) begin
            idx = 5'd31;
            tgt = 1'b0;
         end
         if (i == 6) begin
            idx = 5'd28;
            tgt = 1'b0;
         end
         offer(make_subscribe(id, idx, tgt));
      end
      offer(make_subscribe(8'h99, 5'd3, 1'b1));
      offer(make_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF));
      // This waiter watches a sensor that does not exist and waits for a one, so it stays.
      offer(make_subscribe(8'h33, 5'd28, 1'b1));
      offer(make_subscribe(8'h44, 5'd13, 1'b0));
      offer(make_subscribe(8'hC3, 5'd7, 1'b1));
      offer(make_frame(8'h80, 8'h00, 8'h00, 8'h00));
      offer(make_frame(8'h00, 8'h01, 8'h00, 8'h00));
      offer(make_frame(8'h7F, 8'h7F, 8'h7F, 8'h7F));

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
               sub_pct = 60;
            end
            1: begin
               send_idle_pct = 64;
               rsp_stall_pct = 0;
               sub_pct = 70;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 64;
               sub_pct = 45;
            end
            default: begin
               send_idle_pct = 27;
               rsp_stall_pct = 27;
               sub_pct = 55;
            end
         endcase
         repeat (44) offer(random_item(sub_pct));
         if (phase == 0) begin
            hold_flip = ~hold_flip;
            repeat (12) offer(random_item(100));
         end
      end
      req_valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items in %0d cycles, %0d of them frames.",
               items_sent, cycles, frame_total);
      $display("Waiters stored %0d, dropped on a full table %0d, released %0d; mismatches %0d.",
               stored_total, dropped_total, released_total, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
